[hw/rtl/pal_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants of the positional array list
// Entry, request and response layouts, operation codes and list sizing.
// ----------------------------------------------------------------------------
package pal_pkg;

    // Sizing is fixed by the 6-bit position and count fields.
    localparam int LIST_DEPTH  = 32;
    localparam int TITLE_BYTES = 8;
    localparam int TITLE_W     = 64;
    localparam int TIME_W      = 16;
    localparam int POS_W       = 6;
    localparam int CNT_W       = 6;
    localparam int IDX_W       = $clog2(LIST_DEPTH);
    localparam int FOUND_W     = 5;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    typedef struct packed {
        logic [TITLE_W-1:0] title;
        logic [TIME_W-1:0]  play_time;
    } t_entry;

    // Per-cell command: load the new entry, take the left or the right neighbor.
    typedef struct packed {
        logic load;
        logic from_prev;
        logic from_next;
    } t_cell_ctl;

    typedef struct packed {
        logic [2:0]         op;
        logic [POS_W-1:0]   position;
        logic               append;
        logic [TITLE_W-1:0] new_title;
        logic [TIME_W-1:0]  new_play_time;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [FOUND_W-1:0] found_position;
        logic [TITLE_W-1:0] read_title;
        logic [TIME_W-1:0]  read_play_time;
        logic [CNT_W-1:0]   entry_count;
    } t_rsp;

endpackage
`default_nettype wire

[hw/rtl/pal_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pal_cell: one position of the list
// Holds one entry, shifts it to or from its neighbors and compares its title.
// ----------------------------------------------------------------------------
module pal_cell
    import pal_pkg::*;
(
    input  wire                i_clk,
    input  wire  t_cell_ctl    i_ctl,
    input  wire  t_entry       i_prev,
    input  wire  t_entry       i_next,
    input  wire  t_entry       i_new,
    input  wire  [TITLE_W-1:0] i_key,
    output t_entry             o_entry,
    output logic               o_match
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_match;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_new;
        end else if (i_ctl.from_prev) begin
            n_entry = i_prev;
        end else if (i_ctl.from_next) begin
            n_entry = i_next;
        end
    end

    // The match is taken on the contents before this cycle's update.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= (r_entry.title == i_key);
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule
`default_nettype wire

[hw/rtl/positional_array_list.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list: bounded ordered list of titled entries
// Insert, delete, get, update, find and clear over a shifting row of cells.
// ----------------------------------------------------------------------------
// A request item is taken at a rising edge where start is high and busy is
// low. Each request gives exactly one response item on o_rsp, marked by a
// one-cycle o_done strobe; the receiver cannot hold it off.
// Sequence: the request is accepted in S_IDLE, the row of cells executes the
// insert, delete or update shift in S_EXEC while every cell registers its
// title compare, and the response is registered in S_RESP after the
// first-match priority encoder, with o_done raised alongside it. busy is high
// in S_EXEC and S_RESP, so the block takes no new item until the response is
// out; the three-step sequence (accept, cell update, priority encode) allows
// no overlap between requests.
// All entries shift in the same cycle regardless of position or count.
// Titles are cut to P_TITLE_BYTES bytes and cleared after their first zero
// byte before they are stored or compared.
// Reset (synchronous, active low) empties the list and clears busy and
// o_done; entry contents are not cleared, as only entries below the count
// are ever read.
// ----------------------------------------------------------------------------
module positional_array_list
    import pal_pkg::*;
#(
    parameter int P_TITLE_BYTES = TITLE_BYTES
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_done,
    output t_rsp      o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state           r_state;
    t_req             r_req;
    t_req             w_req_in;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ok;
    logic             n_ok;
    logic             r_is_find;
    t_entry           r_rd;
    t_entry           n_rd;

    t_entry           w_entry [LIST_DEPTH];
    logic             w_match [LIST_DEPTH];
    t_cell_ctl        w_ctl   [LIST_DEPTH];

    logic             w_exec;
    logic             w_ins_ok;
    logic             w_del_ok;
    logic             w_upd_ok;
    logic             w_get_ok;
    logic [POS_W-1:0] w_ins_pos;
    t_entry           w_new;
    logic             w_hit_any;
    logic [FOUND_W-1:0] w_found;

    // Keep the first title bytes up to the first zero byte.
    function automatic logic [TITLE_W-1:0] f_norm(input logic [TITLE_W-1:0] t);
        logic               alive;
        logic [TITLE_W-1:0] r;
        alive = 1'b1;
        r     = '0;
        for (int b = 0; b < 8; b++) begin
            if (b >= P_TITLE_BYTES || t[8*b +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                r[8*b +: 8] = t[8*b +: 8];
            end
        end
        return r;
    endfunction

    // The request as it is held: the title is normalized on the way in.
    always_comb begin
        w_req_in           = i_req;
        w_req_in.new_title = f_norm(i_req.new_title);
    end

    assign busy   = (r_state != S_IDLE);
    assign w_exec = (r_state == S_EXEC);

    // Operation decode for the execute cycle.
    always_comb begin
        w_ins_pos = r_req.append ? r_count : r_req.position;
        w_ins_ok  = (r_req.op == OP_INSERT) && (r_count < CNT_W'(LIST_DEPTH))
                    && (r_req.append || (r_req.position <= r_count));
        w_del_ok  = (r_req.op == OP_DELETE) && (r_req.position < r_count);
        w_get_ok  = (r_req.op == OP_GET)    && (r_req.position < r_count);
        w_upd_ok  = (r_req.op == OP_UPDATE) && (r_req.position < r_count);
        w_new     = '{title: r_req.new_title, play_time: r_req.new_play_time};
    end

    always_comb begin
        n_count = r_count;
        n_ok    = 1'b0;
        if (w_ins_ok) begin
            n_count = r_count + 1'b1;
            n_ok    = 1'b1;
        end else if (w_del_ok) begin
            n_count = r_count - 1'b1;
            n_ok    = 1'b1;
        end else if (w_get_ok || w_upd_ok) begin
            n_ok = 1'b1;
        end else if (r_req.op == OP_CLEAR) begin
            n_count = '0;
            n_ok    = 1'b1;
        end
        n_rd = '0;
        if (w_get_ok) begin
            n_rd = w_entry[r_req.position[IDX_W-1:0]];
        end
    end

    // The row of cells: each one decides from its own index what to take.
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        localparam logic [CNT_W-1:0] CI  = CNT_W'(i);
        localparam logic [CNT_W-1:0] CI1 = CNT_W'(i + 1);
        t_entry w_prev;
        t_entry w_next;

        if (i == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_entry[i-1];
        end
        if (i == LIST_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_next
            assign w_next = w_entry[i+1];
        end

        always_comb begin
            w_ctl[i].load      = w_exec && ((w_ins_ok && CI == w_ins_pos)
                                 || (w_upd_ok && CI == r_req.position));
            w_ctl[i].from_prev = w_exec && w_ins_ok && (CI > w_ins_pos)
                                 && (CI <= r_count);
            w_ctl[i].from_next = w_exec && w_del_ok && (CI >= r_req.position)
                                 && (CI1 < r_count);
        end

        pal_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[i]),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_new   (w_new),
            .i_key   (r_req.new_title),
            .o_entry (w_entry[i]),
            .o_match (w_match[i])
        );
    end

    // First occupied cell whose title matched the key.
    always_comb begin
        w_hit_any = 1'b0;
        w_found   = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (w_match[i] && (CNT_W'(i) < r_count)) begin
                w_hit_any = 1'b1;
                w_found   = FOUND_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= w_req_in;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_count   <= n_count;
                    r_ok      <= n_ok;
                    r_rd      <= n_rd;
                    r_is_find <= (r_req.op == OP_FIND);
                    r_state   <= S_RESP;
                end
                S_RESP: begin
                    o_done               <= 1'b1;
                    o_rsp.ok             <= r_is_find ? w_hit_any : r_ok;
                    o_rsp.found_position <= r_is_find ? w_found : '0;
                    o_rsp.read_title     <= r_rd.title;
                    o_rsp.read_play_time <= r_rd.play_time;
                    o_rsp.entry_count    <= r_count;
                    r_state              <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.entry_count <= CNT_W'(LIST_DEPTH)))
        else $error("entry count beyond list depth");

    // Every request that finishes its work produces a response.
    a_done_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && $past(i_rst_n) && $fell(busy)) |-> o_done)
        else $error("busy released without a response");

    // A response is never shown while a request is still in work.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("response strobe while busy");

    // A failed request never returns entry data.
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.ok) |-> (o_rsp.read_title == '0 && o_rsp.read_play_time == '0))
        else $error("failed request returned entry data");
`endif

endmodule
`default_nettype wire
